/* hdl/lgs_pkg.sv */
// ----------------------------------------------------------------------------
// Life grid package
// Shared types and constants for the toroidal Life grid block.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

  localparam int DEF_GRID_ROWS = 32;
  localparam int DEF_GRID_COLS = 32;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 5;
  localparam int CMD_W  = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;

  localparam logic [0:0] REG_RUN_ENABLE = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_MODIFY,
    ST_LOAD_UP,
    ST_LOAD_MID,
    ST_LOAD_DN,
    ST_ROW_LOAD,
    ST_CELL,
    ST_ROW_WRITE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* hdl/life_grid_generation_step.sv */
// ----------------------------------------------------------------------------
// Life grid generation step
// Toroidal Life grid with cell write, cell read and one-generation step.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                      Payload
//   -------   ----------------------------   ------------------------------
//   config    psel/penable/pwrite, pready=1   paddr, pwdata, prdata
//   input     in_valid / in_ready             cmd, row, col, cell_in
//   output    out_valid / out_ready           cell_out, advanced
//
// The grid is held one row per memory word in two banks that swap roles
// after each generation. A step transaction passes every cell through the
// single neighbor-count unit, which visits one cell per cycle.
// After reset the block clears the grid, one row at a time, before it
// accepts a transaction. A stalled result is held in the output register,
// and the next transaction is accepted once the block is back in idle.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_generation_step
  import lgs_pkg::*;
#(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [CMD_W-1:0]   cmd,
  input  wire logic [ROW_W-1:0]   row,
  input  wire logic [COL_W-1:0]   col,
  input  wire logic               cell_in,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic               cell_out,
  output      logic               advanced
);

  localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int AW    = RW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);
  localparam logic [RW:0]   ROWS_EXT = (RW+1)'(GRID_ROWS);
  localparam logic [RW:0]   ROW_STEP = (RW+1)'(2);

  state_t state;
  state_t state_next;

  logic run_enable;
  logic bank;
  logic [RW-1:0] rctr;
  logic [CW-1:0] cctr;

  logic [CMD_W-1:0] op_cmd;
  logic [RW-1:0]    op_row;
  logic [CW-1:0]    op_col;
  logic             op_val;
  logic             res_cell;
  logic             res_adv;

  logic [GRID_COLS-1:0] win_up;
  logic [GRID_COLS-1:0] win_mid;
  logic [GRID_COLS-1:0] win_dn;
  logic [GRID_COLS-1:0] res_row;

  logic [GRID_COLS-1:0] mem [DEPTH];
  logic [GRID_COLS-1:0] mem_rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic [GRID_COLS-1:0] mem_wdata;

  logic                 in_fire;
  logic                 in_hit;
  logic                 out_load;
  logic                 cfg_write;
  logic [RW:0]          row_sum;
  logic [RW-1:0]        row_ahead;
  logic [GRID_COLS-1:0] mod_row;
  logic [7:0]           nbrs;
  logic [3:0]           nbr_count;
  logic                 new_cell;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2:2] == REG_RUN_ENABLE);
  assign prdata    = (paddr[2:2] == REG_RUN_ENABLE) ? {{(PDATA_W-1){1'b0}}, run_enable}
                                                    : '0;

  assign in_fire = in_valid && in_ready;
  assign in_hit  = (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLS);

  assign row_sum   = {1'b0, rctr} + ROW_STEP;
  assign row_ahead = (row_sum >= ROWS_EXT) ? RW'(row_sum - ROWS_EXT) : RW'(row_sum);

  always_comb begin
    mod_row         = mem_rdata;
    mod_row[op_col] = op_val;
  end

  assign nbrs = {win_up[GRID_COLS-1], win_up[0], win_up[1],
                 win_mid[GRID_COLS-1], win_mid[1],
                 win_dn[GRID_COLS-1], win_dn[0], win_dn[1]};
  assign nbr_count = 4'($countones(nbrs));
  assign new_cell  = (nbr_count == 4'(BIRTH_COUNT)) ||
                     (win_mid[0] && (nbr_count == 4'(SURVIVE_COUNT)));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (rctr == ROW_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if ((cmd == CMD_READ || cmd == CMD_WRITE) && in_hit) begin
            state_next = ST_FETCH;
          end else if (cmd == CMD_STEP && run_enable) begin
            state_next = ST_LOAD_UP;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_FETCH:     state_next = ST_MODIFY;
      ST_MODIFY:    state_next = ST_DONE;
      ST_LOAD_UP:   state_next = ST_LOAD_MID;
      ST_LOAD_MID:  state_next = ST_LOAD_DN;
      ST_LOAD_DN:   state_next = ST_ROW_LOAD;
      ST_ROW_LOAD:  state_next = ST_CELL;
      ST_CELL: begin
        if (cctr == COL_LAST) state_next = ST_ROW_WRITE;
      end
      ST_ROW_WRITE: begin
        state_next = (rctr == ROW_LAST) ? ST_DONE : ST_ROW_LOAD;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = {bank, rctr};
    mem_wdata = res_row;
    mem_raddr = {bank, op_row};
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b0, rctr};
        mem_wdata = '0;
      end
      ST_IDLE:     in_ready = 1'b1;
      ST_FETCH:    mem_raddr = {bank, op_row};
      ST_MODIFY: begin
        mem_we    = (op_cmd == CMD_WRITE);
        mem_waddr = {bank, op_row};
        mem_wdata = mod_row;
      end
      ST_LOAD_UP:  mem_raddr = {bank, ROW_LAST};
      ST_LOAD_MID: mem_raddr = {bank, RW'(0)};
      ST_LOAD_DN:  mem_raddr = {bank, RW'(1)};
      ST_ROW_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = {~bank, rctr};
        mem_wdata = res_row;
        mem_raddr = {bank, row_ahead};
      end
      ST_DONE:     out_load = !out_valid || out_ready;
      default:     in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      run_enable <= 1'b0;
      bank       <= 1'b0;
      rctr       <= '0;
      cctr       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) run_enable <= pwdata[0];
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          rctr <= (rctr == ROW_LAST) ? '0 : rctr + RW'(1);
        end
        ST_IDLE: begin
          rctr <= '0;
          cctr <= '0;
        end
        ST_ROW_LOAD: cctr <= '0;
        ST_CELL:     cctr <= cctr + CW'(1);
        ST_ROW_WRITE: begin
          if (rctr == ROW_LAST) begin
            bank <= ~bank;
            rctr <= '0;
          end else begin
            rctr <= rctr + RW'(1);
          end
        end
        default: begin
          rctr <= rctr;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_cmd   <= cmd;
      op_row   <= RW'(row);
      op_col   <= CW'(col);
      op_val   <= cell_in;
      res_cell <= 1'b0;
      res_adv  <= 1'b0;
    end
    if (out_load) begin
      cell_out <= res_cell;
      advanced <= res_adv;
    end
    case (state)
      ST_MODIFY: begin
        if (op_cmd == CMD_READ) res_cell <= mem_rdata[op_col];
      end
      ST_LOAD_MID: win_up <= mem_rdata;
      ST_LOAD_DN:  win_mid <= mem_rdata;
      ST_ROW_LOAD: win_dn <= mem_rdata;
      ST_CELL: begin
        win_up  <= {win_up[0], win_up[GRID_COLS-1:1]};
        win_mid <= {win_mid[0], win_mid[GRID_COLS-1:1]};
        win_dn  <= {win_dn[0], win_dn[GRID_COLS-1:1]};
        res_row <= {new_cell, res_row[GRID_COLS-1:1]};
      end
      ST_ROW_WRITE: begin
        win_up  <= win_mid;
        win_mid <= win_dn;
        if (rctr == ROW_LAST) res_adv <= 1'b1;
      end
      default: begin
        res_row <= res_row;
      end
    endcase
  end

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Life grid generation step testbench
// Drives cell writes, cell reads, generation steps and the unused command code
// into the toroidal Life grid. It keeps its own copy of the grid to predict
// every result, and runs under random source gaps and sink stalls. Patterns are
// seeded in small windows, which often straddle the grid edges, then stepped
// and read back. The run flag is switched between phases.
// ----------------------------------------------------------------------------
module tb
  import lgs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_R = DEF_GRID_ROWS;
  localparam int GRID_C = DEF_GRID_COLS;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int PHASE_ITEMS = 84;
  localparam logic [5:0] RUN_PLAN = 6'b101101;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam logic [PADDR_W-1:0] RUN_ADDR = PADDR_W'(4 * REG_RUN_ENABLE);

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [ROW_W-1:0] at_row;
    logic [COL_W-1:0] at_col;
    logic             value;
  } life_item_t;

  typedef struct packed {
    logic cell_out;
    logic advanced;
  } life_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = '0;
  logic [ROW_W-1:0] row = '0;
  logic [COL_W-1:0] col = '0;
  logic cell_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic cell_out;
  logic advanced;

  logic [GRID_C-1:0] life [GRID_R];
  logic run_on = 1'b0;

  life_item_t pending_q[$];
  life_result_t result_q[$];
  life_item_t cur_item;
  life_result_t want;

  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int errs = 0;
  int cycle_count = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int gen_count = 0;
  int idle_left = 0;
  int stall_left = 0;
  logic in_fire = 1'b0;
  logic calm = 1'b0;

  life_grid_generation_step dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .row(row),
    .col(col),
    .cell_in(cell_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cell_out(cell_out),
    .advanced(advanced)
  );

  initial forever #1 clk = ~clk;

  function automatic void advance_life();
    logic [GRID_C-1:0] fresh [GRID_R];
    int up, dn, lf, rt, n;
    for (int r = 0; r < GRID_R; r++) begin
      up = (r + GRID_R - 1) % GRID_R;
      dn = (r + 1) % GRID_R;
      for (int c = 0; c < GRID_C; c++) begin
        lf = (c + GRID_C - 1) % GRID_C;
        rt = (c + 1) % GRID_C;
        n = int'(life[up][lf]) + int'(life[up][c]) + int'(life[up][rt])
          + int'(life[r][lf]) + int'(life[r][rt])
          + int'(life[dn][lf]) + int'(life[dn][c]) + int'(life[dn][rt]);
        if (life[r][c]) begin
          fresh[r][c] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
        end else begin
          fresh[r][c] = (n == BIRTH_COUNT);
        end
      end
    end
    life = fresh;
  endfunction

  function automatic life_result_t apply_item(life_item_t it);
    life_result_t res;
    logic hit;
    res = '0;
    hit = (int'(it.at_row) < GRID_R) && (int'(it.at_col) < GRID_C);
    case (it.op)
      CMD_WRITE: begin
        if (hit) life[it.at_row][it.at_col] = it.value;
      end
      CMD_READ: begin
        if (hit) res.cell_out = life[it.at_row][it.at_col];
      end
      CMD_STEP: begin
        if (run_on) begin
          advance_life();
          res.advanced = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void flag_error(string msg);
    errs++;
    if (errs <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void queue_item(logic [CMD_W-1:0] op, logic [ROW_W-1:0] r,
                                     logic [COL_W-1:0] c, logic v);
    pending_q.push_back('{op: op, at_row: r, at_col: c, value: v});
    n_queued++;
  endfunction

  // Seed a small window, queue up to three steps, then read around it.
  function automatic void pattern_burst();
    logic [ROW_W-1:0] r0;
    logic [COL_W-1:0] c0;
    r0 = ROW_W'($urandom_range(0, GRID_R - 1));
    c0 = COL_W'($urandom_range(0, GRID_C - 1));
    repeat ($urandom_range(3, 10))
      queue_item(CMD_WRITE, ROW_W'(r0 + $urandom_range(0, 4)),
                 COL_W'(c0 + $urandom_range(0, 4)), $urandom_range(0, 2) != 0);
    repeat ($urandom_range(0, 3))
      queue_item(CMD_STEP, ROW_W'($urandom), COL_W'($urandom), 1'($urandom));
    repeat ($urandom_range(6, 14))
      queue_item(CMD_READ, ROW_W'(r0 + $urandom_range(0, 6) + GRID_R - 1),
                 COL_W'(c0 + $urandom_range(0, 6) + GRID_C - 1), 1'($urandom));
  endfunction

  function automatic void noise_items();
    repeat ($urandom_range(1, 4))
      queue_item(CMD_W'($urandom_range(0, 3)), ROW_W'($urandom), COL_W'($urandom),
                 1'($urandom));
  endfunction

  task automatic drain();
    do @(negedge clk); while (n_accepted != n_queued || result_q.size() != 0);
  endtask

  task automatic write_run(logic v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= RUN_ADDR;
    pwdata <= PDATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    run_on = v;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        idle_left = $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else begin
        cur_item = pending_q.pop_front();
        cmd <= cur_item.op;
        row <= cur_item.at_row;
        col <= cur_item.at_col;
        cell_in <= cur_item.value;
        in_valid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      in_fire = !rst && in_valid && in_ready;
      if (in_fire) begin
        want = apply_item('{op: cmd, at_row: row, at_col: col, value: cell_in});
        result_q.push_back(want);
        n_accepted++;
        op_count[cmd]++;
        if (want.advanced) gen_count++;
      end
      if (!rst && out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          flag_error($sformatf("result with nothing expected: cell_out %0b advanced %0b",
                               cell_out, advanced));
        end else begin
          want = result_q.pop_front();
          if (cell_out !== want.cell_out)
            flag_error($sformatf("result %0d cell_out expected %0b got %0b",
                                 n_checked, want.cell_out, cell_out));
          if (advanced !== want.advanced)
            flag_error($sformatf("result %0d advanced expected %0b got %0b",
                                 n_checked, want.advanced, advanced));
          n_checked++;
        end
      end
    end
  end

  initial begin
    int target;
    for (int r = 0; r < GRID_R; r++) life[r] = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    write_run(1'b0);
    queue_item(CMD_READ, 5'd0, 5'd0, 1'b0);
    queue_item(CMD_WRITE, 5'd31, 5'd31, 1'b1);
    queue_item(CMD_WRITE, 5'd0, 5'd31, 1'b1);
    queue_item(CMD_WRITE, 5'd1, 5'd31, 1'b1);
    queue_item(CMD_SPARE, 5'd31, 5'd31, 1'b1);
    queue_item(CMD_STEP, 5'd0, 5'd0, 1'b0);
    queue_item(CMD_READ, 5'd0, 5'd31, 1'b0);
    queue_item(CMD_WRITE, 5'd15, 5'd15, 1'b1);
    queue_item(CMD_WRITE, 5'd15, 5'd15, 1'b0);
    queue_item(CMD_READ, 5'd15, 5'd15, 1'b1);

    write_run(1'b1);
    queue_item(CMD_STEP, 5'd31, 5'd31, 1'b1);
    queue_item(CMD_READ, 5'd0, 5'd30, 1'b0);
    queue_item(CMD_READ, 5'd0, 5'd0, 1'b0);
    queue_item(CMD_READ, 5'd31, 5'd31, 1'b0);
    queue_item(CMD_READ, 5'd0, 5'd31, 1'b0);
    queue_item(CMD_STEP, 5'd0, 5'd0, 1'b0);
    queue_item(CMD_READ, 5'd31, 5'd31, 1'b0);
    queue_item(CMD_READ, 5'd1, 5'd31, 1'b0);
    queue_item(CMD_READ, 5'd0, 5'd0, 1'b0);
    queue_item(CMD_SPARE, 5'd0, 5'd0, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      write_run(RUN_PLAN[ph]);
      if (ph == 5) calm = 1'b1;
      target = n_queued + PHASE_ITEMS;
      while (n_queued < target) begin
        if ($urandom_range(0, 4) == 0) noise_items();
        else pattern_burst();
      end
    end

    drain();
    repeat (64) @(posedge clk);
    if (result_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", result_q.size()));
    $display("summary: %0d transactions: %0d writes, %0d reads, %0d steps, %0d unused code",
             n_accepted, op_count[CMD_WRITE], op_count[CMD_READ], op_count[CMD_STEP],
             op_count[CMD_SPARE]);
    $display("summary: %0d generations advanced, %0d results checked, %0d mismatches",
             gen_count, n_checked, errs);
    if (errs == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/lgs_pkg.sv
hdl/life_grid_generation_step.sv
test/tb.sv
